// File: src/fdci_pkg.sv
// shared types, constants and controller command/status structs for the
// fractional delay cubic interpolator; no dependencies
package fdci_pkg;

    localparam int DEPTH    = 4096;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int SAMPLE_W = 24;
    localparam int FRAC_W   = 16;
    localparam int DELAY_W  = ADDR_W + FRAC_W;
    localparam int COEF_W   = SAMPLE_W + 3;
    localparam int MUL_W    = SAMPLE_W + 20;
    localparam int ACC_W    = MUL_W + FRAC_W + 1;
    localparam int RND_W    = ACC_W - 2 * FRAC_W;

    typedef logic        [ADDR_W-1:0]   addr_t;
    typedef logic        [FRAC_W-1:0]   frac_t;
    typedef logic        [DELAY_W-1:0]  delay_t;
    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [COEF_W-1:0]   coef_t;
    typedef logic signed [MUL_W-1:0]    mul_op_t;
    typedef logic signed [ACC_W-1:0]    acc_t;
    typedef logic signed [RND_W-1:0]    rnd_t;

    localparam delay_t  DELAY_RESET = delay_t'(131072);
    localparam delay_t  DELAY_MAX   = delay_t'((DEPTH - 1) << FRAC_W);
    localparam sample_t SAMPLE_MAX  = sample_t'((1 << (SAMPLE_W - 1)) - 1);
    localparam sample_t SAMPLE_MIN  = sample_t'(1 << (SAMPLE_W - 1));

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_M1,
        ST_RD_0,
        ST_RD_1,
        ST_RD_2,
        ST_CAP,
        ST_COEF,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        TAP_M1,
        TAP_0,
        TAP_1,
        TAP_2
    } tap_t;

    typedef enum logic [1:0] {
        STEP_1,
        STEP_2,
        STEP_3
    } step_t;

    typedef struct packed {
        logic  accept;
        logic  rd_issue;
        tap_t  rd_tap;
        logic  cap_en;
        tap_t  cap_tap;
        logic  coef_en;
        logic  mul_en;
        step_t step;
        logic  finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_busy;
    } dp_status_t;

endpackage

// File: src/fdci_ram.sv
// generic simple dual-address ram, one write and one read port, registered read
// no dependencies
module fdci_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: src/fdci_ctrl.sv
// sequencing state machine: buffer write, four tap reads, coefficient step,
// three horner passes on the shared multiplier, result hand-off; uses fdci_pkg
module fdci_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  fdci_pkg::dp_status_t  status,
    output fdci_pkg::ctrl_cmd_t   cmd
);

    fdci_pkg::state_t state_reg;
    fdci_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fdci_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        in_stall      = 1'b1;
        cmd           = '0;
        cmd.rd_tap    = fdci_pkg::TAP_M1;
        cmd.cap_tap   = fdci_pkg::TAP_M1;
        cmd.step      = fdci_pkg::STEP_1;
        unique case (state_reg)
            fdci_pkg::ST_IDLE:
            begin
                in_stall   = 1'b0;
                cmd.accept = in_valid;
                if (in_valid)
                begin
                    state_next = fdci_pkg::ST_RD_M1;
                end
            end
            fdci_pkg::ST_RD_M1:
            begin
                cmd.rd_issue = 1'b1;
                cmd.rd_tap   = fdci_pkg::TAP_M1;
                state_next   = fdci_pkg::ST_RD_0;
            end
            fdci_pkg::ST_RD_0:
            begin
                cmd.rd_issue = 1'b1;
                cmd.rd_tap   = fdci_pkg::TAP_0;
                cmd.cap_en   = 1'b1;
                cmd.cap_tap  = fdci_pkg::TAP_M1;
                state_next   = fdci_pkg::ST_RD_1;
            end
            fdci_pkg::ST_RD_1:
            begin
                cmd.rd_issue = 1'b1;
                cmd.rd_tap   = fdci_pkg::TAP_1;
                cmd.cap_en   = 1'b1;
                cmd.cap_tap  = fdci_pkg::TAP_0;
                state_next   = fdci_pkg::ST_RD_2;
            end
            fdci_pkg::ST_RD_2:
            begin
                cmd.rd_issue = 1'b1;
                cmd.rd_tap   = fdci_pkg::TAP_2;
                cmd.cap_en   = 1'b1;
                cmd.cap_tap  = fdci_pkg::TAP_1;
                state_next   = fdci_pkg::ST_CAP;
            end
            fdci_pkg::ST_CAP:
            begin
                cmd.cap_en  = 1'b1;
                cmd.cap_tap = fdci_pkg::TAP_2;
                state_next  = fdci_pkg::ST_COEF;
            end
            fdci_pkg::ST_COEF:
            begin
                cmd.coef_en = 1'b1;
                state_next  = fdci_pkg::ST_MUL1;
            end
            fdci_pkg::ST_MUL1:
            begin
                cmd.mul_en = 1'b1;
                cmd.step   = fdci_pkg::STEP_1;
                state_next = fdci_pkg::ST_MUL2;
            end
            fdci_pkg::ST_MUL2:
            begin
                cmd.mul_en = 1'b1;
                cmd.step   = fdci_pkg::STEP_2;
                state_next = fdci_pkg::ST_MUL3;
            end
            fdci_pkg::ST_MUL3:
            begin
                cmd.mul_en = 1'b1;
                cmd.step   = fdci_pkg::STEP_3;
                state_next = fdci_pkg::ST_FINISH;
            end
            fdci_pkg::ST_FINISH:
            begin
                // wait until the output register can take the result
                if (!status.out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = fdci_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fdci_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: src/fdci_datapath.sv
// datapath: delay register, ring buffer, tap registers, coefficient logic,
// shared horner multiplier, rounding, saturation and output register
// uses fdci_pkg and fdci_ram
module fdci_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  fdci_pkg::ctrl_cmd_t           cmd,
    output fdci_pkg::dp_status_t          status,
    input  logic [fdci_pkg::SAMPLE_W-1:0] sample_in,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [fdci_pkg::DELAY_W-1:0]  delay_q16,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [fdci_pkg::SAMPLE_W-1:0] sample_out
);

    fdci_pkg::delay_t  delay_reg;
    fdci_pkg::addr_t   wi_reg;
    logic              wrapped_reg;
    fdci_pkg::addr_t   i0_reg;
    fdci_pkg::frac_t   frac_reg;
    logic              rd_ok_reg;
    fdci_pkg::sample_t ym1_reg;
    fdci_pkg::sample_t y0_reg;
    fdci_pkg::sample_t y1_reg;
    fdci_pkg::sample_t y2_reg;
    fdci_pkg::coef_t   c1_reg;
    fdci_pkg::coef_t   c2_reg;
    fdci_pkg::coef_t   c3_reg;
    fdci_pkg::acc_t    acc_reg;
    logic              out_valid_reg;
    fdci_pkg::sample_t out_reg;

    fdci_pkg::delay_t  delay_sat;
    fdci_pkg::delay_t  pos;
    fdci_pkg::addr_t   raddr;
    logic [fdci_pkg::SAMPLE_W-1:0] rdata;
    fdci_pkg::sample_t tap_val;
    fdci_pkg::coef_t   c3_next;
    fdci_pkg::coef_t   c2_next;
    fdci_pkg::coef_t   c1_next;
    fdci_pkg::mul_op_t mul_op;
    logic signed [fdci_pkg::FRAC_W:0] frac_s;
    fdci_pkg::acc_t    product;
    fdci_pkg::acc_t    addend;
    fdci_pkg::acc_t    acc_next;
    fdci_pkg::acc_t    rsum;
    fdci_pkg::rnd_t    rounded;
    fdci_pkg::sample_t sat_val;

    assign cfg_ready = 1'b1;

    // read position: write index minus clamped delay, wrapping over the ring
    assign delay_sat = (delay_reg > fdci_pkg::DELAY_MAX) ? fdci_pkg::DELAY_MAX : delay_reg;
    assign pos       = {wi_reg, fdci_pkg::frac_t'(0)} - delay_sat;

    always_comb
    begin
        case (cmd.rd_tap)
            fdci_pkg::TAP_M1: raddr = i0_reg - fdci_pkg::addr_t'(1);
            fdci_pkg::TAP_0:  raddr = i0_reg;
            fdci_pkg::TAP_1:  raddr = i0_reg + fdci_pkg::addr_t'(1);
            default:          raddr = i0_reg + fdci_pkg::addr_t'(2);
        endcase
    end

    fdci_ram #(
        .WIDTH (fdci_pkg::SAMPLE_W),
        .DEPTH (fdci_pkg::DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (cmd.accept),
        .waddr (wi_reg),
        .wdata (sample_in),
        .re    (cmd.rd_issue),
        .raddr (raddr),
        .rdata (rdata)
    );

    // entries not yet written since reset read as zero
    assign tap_val = rd_ok_reg ? $signed(rdata) : fdci_pkg::sample_t'(0);

    assign c3_next = fdci_pkg::coef_t'(y2_reg) - fdci_pkg::coef_t'(y1_reg)
                   + fdci_pkg::coef_t'(y0_reg) - fdci_pkg::coef_t'(ym1_reg);
    assign c2_next = fdci_pkg::coef_t'(ym1_reg) - fdci_pkg::coef_t'(y0_reg) - c3_next;
    assign c1_next = fdci_pkg::coef_t'(y1_reg) - fdci_pkg::coef_t'(ym1_reg);

    // one multiplier, three horner passes
    assign frac_s = $signed({1'b0, frac_reg});

    always_comb
    begin
        case (cmd.step)
            fdci_pkg::STEP_1:
            begin
                mul_op = fdci_pkg::mul_op_t'(c3_reg);
                addend = fdci_pkg::acc_t'(c2_reg) <<< fdci_pkg::FRAC_W;
            end
            fdci_pkg::STEP_2:
            begin
                mul_op = fdci_pkg::mul_op_t'(acc_reg);
                addend = fdci_pkg::acc_t'(c1_reg) <<< (2 * fdci_pkg::FRAC_W);
            end
            default:
            begin
                mul_op = fdci_pkg::mul_op_t'(acc_reg >>> fdci_pkg::FRAC_W);
                addend = fdci_pkg::acc_t'(y0_reg) <<< (2 * fdci_pkg::FRAC_W);
            end
        endcase
    end

    assign product  = mul_op * frac_s;
    assign acc_next = product + addend;

    // round half up, then saturate
    assign rsum    = acc_reg + (fdci_pkg::acc_t'(1) <<< (2 * fdci_pkg::FRAC_W - 1));
    assign rounded = rsum[fdci_pkg::ACC_W-1:2*fdci_pkg::FRAC_W];

    always_comb
    begin
        if (rounded > fdci_pkg::rnd_t'(fdci_pkg::SAMPLE_MAX))
        begin
            sat_val = fdci_pkg::SAMPLE_MAX;
        end
        else if (rounded < fdci_pkg::rnd_t'(fdci_pkg::SAMPLE_MIN))
        begin
            sat_val = fdci_pkg::SAMPLE_MIN;
        end
        else
        begin
            sat_val = rounded[fdci_pkg::SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg     <= fdci_pkg::DELAY_RESET;
            wi_reg        <= '0;
            wrapped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                delay_reg <= delay_q16;
            end
            if (cmd.finish)
            begin
                wi_reg <= wi_reg + fdci_pkg::addr_t'(1);
                if (wi_reg == fdci_pkg::addr_t'(fdci_pkg::DEPTH - 1))
                begin
                    wrapped_reg <= 1'b1;
                end
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            i0_reg   <= pos[fdci_pkg::DELAY_W-1:fdci_pkg::FRAC_W];
            frac_reg <= pos[fdci_pkg::FRAC_W-1:0];
        end
        if (cmd.rd_issue)
        begin
            rd_ok_reg <= wrapped_reg || (raddr <= wi_reg);
        end
        if (cmd.cap_en)
        begin
            case (cmd.cap_tap)
                fdci_pkg::TAP_M1: ym1_reg <= tap_val;
                fdci_pkg::TAP_0:  y0_reg  <= tap_val;
                fdci_pkg::TAP_1:  y1_reg  <= tap_val;
                default:          y2_reg  <= tap_val;
            endcase
        end
        if (cmd.coef_en)
        begin
            c1_reg <= c1_next;
            c2_reg <= c2_next;
            c3_reg <= c3_next;
        end
        if (cmd.mul_en)
        begin
            acc_reg <= acc_next;
        end
        if (cmd.finish)
        begin
            out_reg <= sat_val;
        end
    end

    assign status.out_busy = out_valid_reg && out_stall;
    assign out_valid       = out_valid_reg;
    assign sample_out      = out_reg;

endmodule

// File: src/fractional_delay_cubic_interp.sv
// top level of the fractional delay line with cubic interpolation
// uses fdci_pkg, fdci_ctrl and fdci_datapath
//
// Each accepted sample is written into a 4096-entry ring buffer, and the sample
// at the write position minus delay_q16 (Q12.16, clamped to 4095 samples) is
// interpolated from its four neighbours with a cubic in the fraction, rounded
// and saturated to 24 bits. From its acceptance, each item runs through the
// four reads of the single-read-port buffer, their capture, a coefficient
// step and three passes through the one shared 44x17 multiplier; in_stall is
// high meanwhile, so the next sample waits. The result sits in an output
// register, so the next sample can be taken while it waits; if the earlier
// result is still held by out_stall when the next one is ready, the block waits
// in its last step until that transfer completes. Buffer entries not
// yet written since reset read as zero through fill tracking; there is no
// clearing pass. delay_q16 may be written whenever the block is idle.
module fractional_delay_cubic_interp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [fdci_pkg::SAMPLE_W-1:0] sample_in,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [fdci_pkg::SAMPLE_W-1:0] sample_out,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [fdci_pkg::DELAY_W-1:0]  delay_q16
);

    fdci_pkg::ctrl_cmd_t  cmd;
    fdci_pkg::dp_status_t status;

    fdci_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    fdci_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .sample_in  (sample_in),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .delay_q16  (delay_q16),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .sample_out (sample_out)
    );

endmodule
